// ===== hw/rtl/pill_dispense_sequencer_core_macros.svh =====
// assertion macros for the pill dispense sequencer core
// no dependencies; included by files that carry concurrent assertions
`ifndef PILL_DISPENSE_SEQUENCER_CORE_MACROS_SVH
`define PILL_DISPENSE_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PDS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define PDS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PDS_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define PDS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/pds_pkg.sv =====
// types, codes and reset constants for the pill dispense sequencer
// no dependencies; imported by pds_step and pill_dispense_sequencer_core
package pds_pkg;

    typedef enum logic [2:0] {
        MODE_WAIT  = 3'd0,
        MODE_IDLE  = 3'd1,
        MODE_DELAY = 3'd2,
        MODE_DISP  = 3'd3,
        MODE_ERR   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        PH_NONE   = 2'd0,
        PH_MOVING = 2'd1,
        PH_DETECT = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_CENTER     = 3'd1,
        OP_LEFT       = 3'd2,
        OP_LONG       = 3'd3,
        OP_CAL_RESULT = 3'd4,
        OP_PIEZO      = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_FIRST_DELAY = 3'd0,
        CFG_INTERVAL    = 3'd1,
        CFG_PILL_LIMIT  = 3'd2,
        CFG_WINDOW      = 3'd3,
        CFG_HOLDOFF     = 3'd4,
        CFG_BLINK       = 3'd5
    } cfg_idx_t;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [31:0] RST_FIRST_DELAY = 32'd5000;
    localparam logic [31:0] RST_INTERVAL    = 32'd30000;
    localparam logic [7:0]  RST_PILL_LIMIT  = 8'd7;
    localparam logic [15:0] RST_WINDOW      = 16'd1000;
    localparam logic [15:0] RST_HOLDOFF     = 16'd50;
    localparam logic [15:0] RST_BLINK       = 16'd200;

    typedef struct packed {
        logic [31:0] first_delay;
        logic [31:0] interval;
        logic [7:0]  pill_limit;
        logic [15:0] window;
        logic [15:0] holdoff;
        logic [15:0] blink;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic        calibrating;
        logic [15:0] steps_held;
        logic        led;
        logic [31:0] mode_timer;
        logic [31:0] interval_timer;
        logic        trigger_pending;
        phase_t      phase;
        logic [15:0] window_timer;
        logic        hit_latched;
        logic [15:0] holdoff_timer;
        logic        holdoff_armed;
        logic [7:0]  pills_done;
    } state_t;

    typedef struct packed {
        mode_t       mode;
        logic        led_on;
        logic        calibrate_request;
        logic        move_request;
        logic [15:0] move_steps;
        logic [7:0]  pill_count;
        logic        pill_seen;
        logic        pill_missing;
        logic        all_done;
        logic        save_request;
    } result_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == '1) ? v : v + 16'd1;
    endfunction

endpackage

// ===== hw/rtl/pds_step.sv =====
// next-state and result logic for one event of the dispense sequencer
// depends on pds_pkg
module pds_step import pds_pkg::*; (
    input  state_t      st,
    input  cfg_t        cfg,
    input  opcode_t     opcode,
    input  logic        cal_ok,
    input  logic [15:0] cal_steps,
    input  logic        move_done,
    output state_t      st_next,
    output result_t     res
);

    always_comb begin
        state_t  n;
        result_t r;
        logic    end_req;
        logic    end_seen;
        logic    try_req;

        n        = st;
        r        = '0;
        end_req  = 1'b0;
        end_seen = 1'b0;
        try_req  = 1'b0;

        unique case (opcode)
            OP_TICK: begin
                n.holdoff_timer = sat_inc16(st.holdoff_timer);
                unique case (st.mode)
                    MODE_WAIT: begin
                        n.mode_timer = sat_inc32(st.mode_timer);
                        if (n.mode_timer >= {16'd0, cfg.blink}) begin
                            n.led        = ~st.led;
                            n.mode_timer = '0;
                        end
                    end
                    MODE_DELAY: begin
                        n.mode_timer = sat_inc32(st.mode_timer);
                        if (n.mode_timer >= cfg.first_delay) begin
                            n.led             = 1'b0;
                            n.trigger_pending = 1'b1;
                            n.interval_timer  = '0;
                            n.phase           = PH_NONE;
                            n.mode            = MODE_DISP;
                            try_req           = 1'b1;
                        end
                    end
                    MODE_DISP: begin
                        n.interval_timer = sat_inc32(st.interval_timer);
                        if (n.interval_timer >= cfg.interval) begin
                            n.interval_timer  = '0;
                            n.trigger_pending = 1'b1;
                        end
                        if (st.phase == PH_MOVING) begin
                            if (move_done) begin
                                n.pills_done   = st.pills_done + 8'd1;
                                r.save_request = 1'b1;
                                n.phase        = PH_DETECT;
                                n.window_timer = '0;
                                if (st.hit_latched) begin
                                    end_req  = 1'b1;
                                    end_seen = 1'b1;
                                end
                            end
                        end else if (st.phase == PH_DETECT) begin
                            n.window_timer = sat_inc16(st.window_timer);
                            if (n.window_timer >= cfg.window) begin
                                end_req = 1'b1;
                            end
                        end
                        try_req = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            OP_CENTER: begin
                if (st.mode == MODE_WAIT && !st.calibrating) begin
                    n.calibrating       = 1'b1;
                    r.calibrate_request = 1'b1;
                end
            end
            OP_LEFT: begin
                if (st.mode == MODE_IDLE) begin
                    n.pills_done   = '0;
                    n.mode_timer   = '0;
                    n.mode         = MODE_DELAY;
                    n.led          = 1'b1;
                    r.save_request = 1'b1;
                end
            end
            OP_LONG: begin
                if (st.mode == MODE_ERR) begin
                    n.mode         = MODE_WAIT;
                    n.mode_timer   = '0;
                    n.led          = 1'b0;
                    r.save_request = 1'b1;
                end
            end
            OP_CAL_RESULT: begin
                if (st.mode == MODE_WAIT && st.calibrating) begin
                    n.calibrating = 1'b0;
                    if (cal_ok) begin
                        n.steps_held   = cal_steps;
                        n.mode         = MODE_IDLE;
                        n.led          = 1'b1;
                        r.save_request = 1'b1;
                    end else begin
                        n.mode = MODE_ERR;
                        n.led  = 1'b0;
                    end
                end
            end
            OP_PIEZO: begin
                if (!(st.holdoff_armed && st.holdoff_timer < cfg.holdoff)) begin
                    n.holdoff_armed = 1'b1;
                    n.holdoff_timer = '0;
                    if (st.mode == MODE_DISP) begin
                        if (st.phase == PH_MOVING) begin
                            n.hit_latched = 1'b1;
                        end else if (st.phase == PH_DETECT) begin
                            end_req  = 1'b1;
                            end_seen = 1'b1;
                            try_req  = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // end of detection window
        if (end_req) begin
            if (end_seen) begin
                r.pill_seen = 1'b1;
            end else begin
                r.pill_missing = 1'b1;
            end
            n.phase       = PH_NONE;
            n.hit_latched = 1'b0;
            if (n.pills_done >= cfg.pill_limit) begin
                n.mode            = MODE_WAIT;
                n.mode_timer      = '0;
                n.led             = 1'b0;
                n.trigger_pending = 1'b0;
                r.all_done        = 1'b1;
                r.save_request    = 1'b1;
            end
        end

        // dispense trigger
        if (try_req && n.mode == MODE_DISP && n.phase == PH_NONE && n.trigger_pending) begin
            if (n.pills_done >= cfg.pill_limit) begin
                n.mode            = MODE_WAIT;
                n.mode_timer      = '0;
                n.led             = 1'b0;
                n.trigger_pending = 1'b0;
                r.all_done        = 1'b1;
                r.save_request    = 1'b1;
            end else begin
                n.trigger_pending = 1'b0;
                if (n.steps_held == '0) begin
                    n.mode = MODE_ERR;
                    n.led  = 1'b0;
                end else begin
                    r.move_request  = 1'b1;
                    r.move_steps    = n.steps_held;
                    n.phase         = PH_MOVING;
                    n.hit_latched   = 1'b0;
                    n.holdoff_armed = 1'b0;
                end
            end
        end

        r.mode       = n.mode;
        r.led_on     = n.led;
        r.pill_count = n.pills_done;

        st_next = n;
        res     = r;
    end

endmodule

// ===== hw/rtl/pill_dispense_sequencer_core.sv =====
// pill dispense sequencer: event input register, single-pass update, result register
// pipeline: input register, then state and result register, two register stages in all
// throughput: one event per cycle, set by the single-pass pds_step, if no result is held
// stalls: a held result holds the input register; s_tready falls once it too is full
// reset: synchronous active-low aresetn clears state and valids, sets register defaults
// depends on pds_pkg, pds_step and pill_dispense_sequencer_core_macros.svh
`include "pill_dispense_sequencer_core_macros.svh"

module pill_dispense_sequencer_core import pds_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // cal_ok, cal_steps[15:0], move_done, zero pad
    input  logic [S_TUSER_W-1:0]  s_tuser,  // opcode[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // mode[2:0], led_on, calibrate_request, move_request, move_steps[15:0],
    // pill_count[7:0], pill_seen, pill_missing, all_done, save_request, zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t        cfg_reg;
    state_t      st_reg;
    state_t      st_next;
    result_t     res_next;
    logic        in_valid_reg;
    opcode_t     in_op_reg;
    logic        in_cal_ok_reg;
    logic [15:0] in_cal_steps_reg;
    logic        in_move_done_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        out_adv;
    logic        fire;
    logic        chk_move;
    logic        chk_move_ok;
    logic        chk_done;
    logic        chk_done_ok;
    logic        chk_busy;
    logic        chk_in_disp;

    assign out_adv   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_adv;
    assign s_tready  = !in_valid_reg || out_adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_delay <= RST_FIRST_DELAY;
            cfg_reg.interval    <= RST_INTERVAL;
            cfg_reg.pill_limit  <= RST_PILL_LIMIT;
            cfg_reg.window      <= RST_WINDOW;
            cfg_reg.holdoff     <= RST_HOLDOFF;
            cfg_reg.blink       <= RST_BLINK;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FIRST_DELAY: cfg_reg.first_delay <= cfg_data;
                CFG_INTERVAL:    cfg_reg.interval    <= cfg_data;
                CFG_PILL_LIMIT:  cfg_reg.pill_limit  <= cfg_data[7:0];
                CFG_WINDOW:      cfg_reg.window      <= cfg_data[15:0];
                CFG_HOLDOFF:     cfg_reg.holdoff     <= cfg_data[15:0];
                CFG_BLINK:       cfg_reg.blink       <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg        <= opcode_t'(s_tuser[2:0]);
            in_cal_ok_reg    <= s_tdata[0];
            in_cal_steps_reg <= s_tdata[16:1];
            in_move_done_reg <= s_tdata[17];
        end
    end

    pds_step u_step (
        .st        (st_reg),
        .cfg       (cfg_reg),
        .opcode    (in_op_reg),
        .cal_ok    (in_cal_ok_reg),
        .cal_steps (in_cal_steps_reg),
        .move_done (in_move_done_reg),
        .st_next   (st_next),
        .res       (res_next)
    );

    // state and result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            st_reg        <= st_next;
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_reg.save_request,
                       out_reg.all_done,
                       out_reg.pill_missing,
                       out_reg.pill_seen,
                       out_reg.pill_count,
                       out_reg.move_steps,
                       out_reg.move_request,
                       out_reg.calibrate_request,
                       out_reg.led_on,
                       out_reg.mode};

    // assertion terms
    assign chk_move    = m_tvalid && out_reg.move_request;
    assign chk_move_ok = (out_reg.move_steps != 16'd0) && (out_reg.mode == MODE_DISP);
    assign chk_done    = m_tvalid && out_reg.all_done;
    assign chk_done_ok = (out_reg.mode == MODE_WAIT) && out_reg.save_request && !out_reg.led_on;
    assign chk_busy    = (st_reg.phase != PH_NONE);
    assign chk_in_disp = (st_reg.mode == MODE_DISP);

    `PDS_ASSERT_SAME(a_move_nonzero, aclk, aresetn, chk_move, chk_move_ok, "bad move request")
    `PDS_ASSERT_SAME(a_done_to_wait, aclk, aresetn, chk_done, chk_done_ok, "bad sequence end")
    `PDS_ASSERT_SAME(a_phase_in_disp, aclk, aresetn, chk_busy, chk_in_disp, "phase outside disp")
    `PDS_ASSERT_NEXT(a_fire_valid, aclk, aresetn, fire, m_tvalid, "result not presented")

endmodule

// ===== bench/sequencer_monitor.sv =====
`timescale 1ns / 100ps
// sequencer_monitor: watches the event, status and register channels of the dispense
// sequencer core, predicts each status transfer and compares it field by field; uses pds_pkg
module sequencer_monitor import pds_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // cal_ok, cal_steps[15:0], move_done, zero pad
    input  logic [S_TUSER_W-1:0]  s_tuser,  // opcode[2:0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // mode[2:0], led_on, calibrate_request, move_request, move_steps[15:0],
    // pill_count[7:0], pill_seen, pill_missing, all_done, save_request, zero pad
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    logic [31:0] first_delay_r, interval_r;
    logic [7:0]  pill_limit_r;
    logic [15:0] window_r, holdoff_r, blink_r;

    mode_t       mode_q;
    logic        cal_busy;
    logic [15:0] steps_q;
    logic        led_q;
    logic [31:0] mode_tmr, intv_tmr;
    logic        trig_pend;
    phase_t      ph_q;
    logic [15:0] win_tmr;
    logic        hit_q;
    logic [15:0] hold_tmr;
    logic        hold_armed;
    logic [7:0]  pills_q;

    result_t nxt, due;
    result_t status_due[$];
    int      mismatches = 0;

    assign fail_count = mismatches;

    function automatic void close_sequence();
        mode_q = MODE_WAIT;
        mode_tmr = '0;
        led_q = 1'b0;
        ph_q = PH_NONE;
        trig_pend = 1'b0;
        nxt.all_done = 1'b1;
        nxt.save_request = 1'b1;
    endfunction

    function automatic void close_window(input logic hit);
        if (hit) nxt.pill_seen = 1'b1;
        else nxt.pill_missing = 1'b1;
        ph_q = PH_NONE;
        hit_q = 1'b0;
        if (pills_q >= pill_limit_r) close_sequence();
    endfunction

    function automatic void fire_trigger();
        if (mode_q != MODE_DISP || ph_q != PH_NONE || !trig_pend) return;
        if (pills_q >= pill_limit_r) begin
            close_sequence();
            return;
        end
        trig_pend = 1'b0;
        if (steps_q == '0) begin
            mode_q = MODE_ERR;
            led_q = 1'b0;
            return;
        end
        nxt.move_request = 1'b1;
        nxt.move_steps = steps_q;
        ph_q = PH_MOVING;
        hit_q = 1'b0;
        hold_armed = 1'b0;
    endfunction

    function automatic void step_tick(input logic done);
        hold_tmr = (hold_tmr == '1) ? hold_tmr : hold_tmr + 16'd1;
        case (mode_q)
            MODE_WAIT: begin
                mode_tmr = (mode_tmr == '1) ? mode_tmr : mode_tmr + 32'd1;
                if (mode_tmr >= blink_r) begin
                    led_q = ~led_q;
                    mode_tmr = '0;
                end
            end
            MODE_DELAY: begin
                mode_tmr = (mode_tmr == '1) ? mode_tmr : mode_tmr + 32'd1;
                if (mode_tmr >= first_delay_r) begin
                    led_q = 1'b0;
                    trig_pend = 1'b1;
                    intv_tmr = '0;
                    ph_q = PH_NONE;
                    mode_q = MODE_DISP;
                    fire_trigger();
                end
            end
            MODE_DISP: begin
                intv_tmr = (intv_tmr == '1) ? intv_tmr : intv_tmr + 32'd1;
                if (intv_tmr >= interval_r) begin
                    intv_tmr = '0;
                    trig_pend = 1'b1;
                end
                if (ph_q == PH_MOVING) begin
                    if (done) begin
                        pills_q = pills_q + 8'd1;
                        nxt.save_request = 1'b1;
                        ph_q = PH_DETECT;
                        win_tmr = '0;
                        if (hit_q) close_window(1'b1);
                    end
                end else if (ph_q == PH_DETECT) begin
                    win_tmr = (win_tmr == '1) ? win_tmr : win_tmr + 16'd1;
                    if (win_tmr >= window_r) close_window(1'b0);
                end
                fire_trigger();
            end
            default: ;
        endcase
    endfunction

    function automatic void step_piezo();
        if (hold_armed && hold_tmr < holdoff_r) return;
        hold_armed = 1'b1;
        hold_tmr = '0;
        if (mode_q != MODE_DISP) return;
        if (ph_q == PH_MOVING) hit_q = 1'b1;
        else if (ph_q == PH_DETECT) begin
            close_window(1'b1);
            fire_trigger();
        end
    endfunction

    function automatic result_t predict_status(input logic [2:0] op, input logic ok,
                                               input logic [15:0] steps, input logic done);
        nxt = '0;
        case (op)
            OP_TICK: step_tick(done);
            OP_CENTER: begin
                if (mode_q == MODE_WAIT && !cal_busy) begin
                    cal_busy = 1'b1;
                    nxt.calibrate_request = 1'b1;
                end
            end
            OP_LEFT: begin
                if (mode_q == MODE_IDLE) begin
                    pills_q = '0;
                    mode_tmr = '0;
                    mode_q = MODE_DELAY;
                    led_q = 1'b1;
                    nxt.save_request = 1'b1;
                end
            end
            OP_LONG: begin
                if (mode_q == MODE_ERR) begin
                    mode_q = MODE_WAIT;
                    mode_tmr = '0;
                    led_q = 1'b0;
                    nxt.save_request = 1'b1;
                end
            end
            OP_CAL_RESULT: begin
                if (mode_q == MODE_WAIT && cal_busy) begin
                    cal_busy = 1'b0;
                    if (ok) begin
                        steps_q = steps;
                        mode_q = MODE_IDLE;
                        led_q = 1'b1;
                        nxt.save_request = 1'b1;
                    end else begin
                        mode_q = MODE_ERR;
                        led_q = 1'b0;
                    end
                end
            end
            OP_PIEZO: step_piezo();
            default: ;
        endcase
        nxt.mode = mode_q;
        nxt.led_on = led_q;
        nxt.pill_count = pills_q;
        return nxt;
    endfunction

    function automatic void check_field(input string tag, input logic [15:0] want,
                                        input logic [15:0] seen);
        if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", tag, want, seen);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            first_delay_r = RST_FIRST_DELAY;
            interval_r = RST_INTERVAL;
            pill_limit_r = RST_PILL_LIMIT;
            window_r = RST_WINDOW;
            holdoff_r = RST_HOLDOFF;
            blink_r = RST_BLINK;
            mode_q = MODE_WAIT;
            cal_busy = 1'b0;
            steps_q = '0;
            led_q = 1'b0;
            mode_tmr = '0;
            intv_tmr = '0;
            trig_pend = 1'b0;
            ph_q = PH_NONE;
            win_tmr = '0;
            hit_q = 1'b0;
            hold_tmr = '0;
            hold_armed = 1'b0;
            pills_q = '0;
            status_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FIRST_DELAY: first_delay_r = cfg_data;
                    CFG_INTERVAL:    interval_r = cfg_data;
                    CFG_PILL_LIMIT:  pill_limit_r = cfg_data[7:0];
                    CFG_WINDOW:      window_r = cfg_data[15:0];
                    CFG_HOLDOFF:     holdoff_r = cfg_data[15:0];
                    CFG_BLINK:       blink_r = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                status_due.push_back(predict_status(s_tuser, s_tdata[0], s_tdata[16:1],
                                                    s_tdata[17]));
            if (m_tvalid && m_tready) begin
                if (status_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected status transfer %0h", m_tdata);
                end else begin
                    due = status_due.pop_front();
                    check_field("mode", 16'(due.mode), 16'(m_tdata[2:0]));
                    check_field("led_on", 16'(due.led_on), 16'(m_tdata[3]));
                    check_field("calibrate_request", 16'(due.calibrate_request),
                                16'(m_tdata[4]));
                    check_field("move_request", 16'(due.move_request), 16'(m_tdata[5]));
                    check_field("move_steps", due.move_steps, m_tdata[21:6]);
                    check_field("pill_count", 16'(due.pill_count), 16'(m_tdata[29:22]));
                    check_field("pill_seen", 16'(due.pill_seen), 16'(m_tdata[30]));
                    check_field("pill_missing", 16'(due.pill_missing), 16'(m_tdata[31]));
                    check_field("all_done", 16'(due.all_done), 16'(m_tdata[32]));
                    check_field("save_request", 16'(due.save_request), 16'(m_tdata[33]));
                end
            end
        end
        pending <= status_due.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// top of the dispense sequencer bench: clock, reset, event and register stimulus, status sink
// depends on pds_pkg, pill_dispense_sequencer_core and sequencer_monitor
module testbench;
    import pds_pkg::*;

    localparam int ITEM_GOAL      = 2000;
    localparam int CALM_FROM      = 1750;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE         = 4;
    localparam int END_WAIT       = 20;
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count, pending;
    int sent = 0;
    int idle_cycles = 0;
    bit calm, no_gaps, long_hold;

    pill_dispense_sequencer_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    sequencer_monitor monitor (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("pill_dispense_sequencer_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // status sink: random stalls, one long hold on request
    initial begin : status_sink
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    task automatic send_event(input logic [2:0] op, input logic ok, input logic [15:0] steps,
                              input logic done);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[0] = ok;
        word[16:1] = steps;
        word[17] = done;
        if (!calm && !no_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= word;
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (sent >= CALM_FROM) calm = 1'b1;
    endtask

    // random payload in every field, the fields the opcode uses too
    task automatic send_op(input logic [2:0] op);
        send_event(op, 1'($urandom_range(0, 1)), 16'($urandom), $urandom_range(0, 9) < 4);
    endtask

    task automatic set_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [31:0] fd, input logic [31:0] iv,
                                input logic [7:0] mx, input logic [15:0] win,
                                input logic [15:0] hold, input logic [15:0] blink);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
        set_reg(CFG_FIRST_DELAY, fd);
        set_reg(CFG_INTERVAL, iv);
        set_reg(CFG_PILL_LIMIT, 32'(mx));
        set_reg(CFG_WINDOW, 32'(win));
        set_reg(CFG_HOLDOFF, 32'(hold));
        set_reg(CFG_BLINK, 32'(blink));
        cfg_valid <= 1'b0;
    endtask

    // calibrate; on failure a long press, else a sequence of ticks, moves, piezo hits with noise
    task automatic run_episode(input int body);
        logic        ok;
        logic [15:0] stp;
        int          pick;
        int          k;
        send_op(OP_CENTER);
        repeat ($urandom_range(0, 3)) send_op(OP_TICK);
        ok = ($urandom_range(0, 7) != 0);
        stp = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
        send_event(OP_CAL_RESULT, ok, stp, 1'($urandom_range(0, 1)));
        if (!ok) begin
            send_op(OP_LONG);
        end else begin
            send_op(OP_LEFT);
            for (k = 0; k < body && sent < ITEM_GOAL; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) send_op(OP_TICK);
                else if (pick < 78) send_op(OP_PIEZO);
                else if (pick < 83) send_op(OP_CENTER);
                else if (pick < 87) send_op(OP_LEFT);
                else if (pick < 91) send_op(OP_LONG);
                else if (pick < 95) send_op(OP_CAL_RESULT);
                else send_op(3'($urandom_range(0, 7)));
            end
            send_op(OP_LONG);
        end
    endtask

    initial begin : stimulus
        logic [31:0] fd, iv;
        logic [7:0]  mx;
        logic [15:0] win, hold, blink;
        int          body, phase_no;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: events outside their mode, failed calibration, recovery, start
        send_event(OP_TICK, 1'b0, 16'h0000, 1'b0);
        send_event(OP_SPARE_A, 1'b1, 16'hFFFF, 1'b1);
        send_event(OP_SPARE_B, 1'b0, 16'h0000, 1'b0);
        send_event(OP_LONG, 1'b1, 16'hFFFF, 1'b1);
        send_event(OP_LEFT, 1'b0, 16'h0000, 1'b0);
        send_event(OP_PIEZO, 1'b0, 16'h0000, 1'b0);
        send_event(OP_CAL_RESULT, 1'b1, 16'h1234, 1'b0);
        send_event(OP_CENTER, 1'b0, 16'h0000, 1'b0);
        send_event(OP_CENTER, 1'b0, 16'h0000, 1'b0);
        send_event(OP_TICK, 1'b0, 16'h0000, 1'b1);
        send_event(OP_CAL_RESULT, 1'b0, 16'hFFFF, 1'b0);
        send_event(OP_TICK, 1'b0, 16'h0000, 1'b0);
        send_event(OP_LONG, 1'b0, 16'h0000, 1'b0);
        send_event(OP_CENTER, 1'b0, 16'h0000, 1'b0);
        send_event(OP_CAL_RESULT, 1'b1, 16'hFFFF, 1'b1);
        send_event(OP_CENTER, 1'b0, 16'h0000, 1'b0);
        send_event(OP_LEFT, 1'b0, 16'h0000, 1'b0);

        // lowest settings: immediate trigger, early hit, limit of one pill, zero steps
        program_regs(32'd0, 32'd1, 8'd1, 16'd1, 16'd0, 16'd1);
        send_event(OP_TICK, 1'b0, 16'h0000, 1'b0);
        send_event(OP_PIEZO, 1'b0, 16'h0000, 1'b0);
        send_event(OP_TICK, 1'b0, 16'h0000, 1'b1);
        send_event(OP_CENTER, 1'b0, 16'h0000, 1'b0);
        send_event(OP_CAL_RESULT, 1'b1, 16'h0000, 1'b0);
        send_event(OP_LEFT, 1'b0, 16'h0000, 1'b0);
        send_event(OP_TICK, 1'b0, 16'h0000, 1'b0);
        send_event(OP_LONG, 1'b0, 16'h0000, 1'b0);

        phase_no = 0;
        while (sent < ITEM_GOAL) begin
            if (phase_no == 0) begin
                fd = '1; iv = '1; mx = '1; win = '1; hold = '1; blink = '1;
            end else if (phase_no == 1) begin
                fd = '0; iv = 32'd1; mx = 8'd1; win = 16'd1; hold = '0; blink = 16'd1;
            end else begin
                fd = $urandom_range(0, 30);
                iv = $urandom_range(1, 40);
                mx = 8'($urandom_range(1, 6));
                win = 16'($urandom_range(1, 25));
                hold = 16'($urandom_range(0, 8));
                blink = 16'($urandom_range(1, 12));
            end
            program_regs(fd, iv, mx, win, hold, blink);
            if (phase_no < 2) body = 40;
            else body = $urandom_range(10, 40) + int'(mx) * (int'(iv) + 8);
            if (body > 300) body = 300;
            if (phase_no == 2) begin
                long_hold = 1'b1;
                no_gaps = 1'b1;
                run_episode(body);
            end
            repeat ($urandom_range(1, 3)) begin
                no_gaps = ($urandom_range(0, 3) == 0);
                if (sent < ITEM_GOAL) run_episode(body);
            end
            no_gaps = 1'b0;
            phase_no++;
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (END_WAIT) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("pill_dispense_sequencer_core test passed");
        end else begin
            $display("pill_dispense_sequencer_core test failed");
        end
        $finish;
    end

endmodule
